### rtl/scm_pkg.sv
// Shared types and constants of the strip common-mode clusterer.
// No dependencies; imported by scm_div, the top level and the testbench.
`default_nettype none
package scm_pkg;

  // Default geometry and fixed-point format.
  localparam int STRIPS_PER_ASIC_DEF = 64;
  localparam int NUM_ASICS_DEF       = 10;
  localparam int FRAC_BITS_DEF       = 4;

  // Port field widths.
  localparam int STRIP_W  = 10;
  localparam int ADC_W    = 12;
  localparam int PED_W    = 16;
  localparam int NOISE_W  = 12;
  localparam int MULT_W   = 4;
  localparam int CENT_W   = 16;
  localparam int ENERGY_W = 22;
  localparam int SIZE_W   = 6;

  // Result formatting and limits.
  localparam int CENT_FRAC   = 6;
  localparam int MAX_RESULTS = 31;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int CENT_MAX    = 65535;
  localparam int ENERGY_MAX  = 4194303;
  localparam int SIZE_MAX    = 63;

  // Configuration registers.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CM_CUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_CUT = 2'd1;
  localparam logic [MULT_W-1:0] CM_CUT_RST  = 4'd6;
  localparam logic [MULT_W-1:0] HIT_CUT_RST = 4'd4;

  // Request kinds.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // One calibration entry as stored in memory.
  typedef struct packed {
    logic               dead;
    logic [NOISE_W-1:0] fine_noise;
    logic [NOISE_W-1:0] raw_noise;
    logic [PED_W-1:0]   pedestal;
  } cal_t;
  localparam int CAL_W = $bits(cal_t);

  // One cluster result without its last flag.
  typedef struct packed {
    logic [CENT_W-1:0]   centroid;
    logic [ENERGY_W-1:0] energy_sum;
    logic [SIZE_W-1:0]   cluster_size;
  } res_t;

  // Divider status toward the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### rtl/scm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module scm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/scm_div.sv
// Restoring divider, one quotient bit per cycle, shared by common mode and centroid.
// Depends on scm_pkg for the status struct.
`default_nettype none
module scm_div #(
  parameter int NW = 40,
  parameter int DW = 23
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NW-1:0]            num,
  input  logic [DW-1:0]            den,
  output scm_pkg::div_stat_t       stat,
  output logic [NW-1:0]            quo
);
  import scm_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  // One trial subtraction per cycle.
  always_comb begin
    trial    = {rem_r, quo_r[NW-1]} - {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW]) begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-2:0], quo_r[NW-1]};
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

  // A new division is only started on an idle unit.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");

  // Completion follows a busy period.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");

endmodule
`default_nettype wire

### rtl/strip_common_mode_clusterer.sv
// Strip common-mode subtraction and clustering, top level.
// A load request writes the calibration store; a sample request reads the calibration, then
// writes the buffer. The last strip of an ASIC then runs a common-mode scan (read, evaluate
// per strip), a NUMW-bit divide (40 by default) on the shared one-bit-per-cycle divider, a
// cluster scan (read, evaluate, multiply, accumulate per strip) and a divide per cluster.
// Synchronous active-low reset clears control state and buffer valid bits; memories keep data.
// Depends on scm_pkg, scm_ram and scm_div.
`default_nettype none
module strip_common_mode_clusterer #(
  parameter int STRIPS_PER_ASIC = scm_pkg::STRIPS_PER_ASIC_DEF,
  parameter int NUM_ASICS       = scm_pkg::NUM_ASICS_DEF,
  parameter int FRAC_BITS       = scm_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [scm_pkg::STRIP_W-1:0]     in_strip,
  input  logic [scm_pkg::ADC_W-1:0]       in_adc,
  input  logic [scm_pkg::PED_W-1:0]       in_pedestal,
  input  logic [scm_pkg::NOISE_W-1:0]     in_raw_noise,
  input  logic [scm_pkg::NOISE_W-1:0]     in_fine_noise,
  input  logic                            in_dead,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [scm_pkg::CENT_W-1:0]      out_centroid,
  output logic [scm_pkg::ENERGY_W-1:0]    out_energy_sum,
  output logic [scm_pkg::SIZE_W-1:0]      out_cluster_size,
  output logic                            out_last_in_asic,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scm_pkg::MULT_W-1:0]      cfg_data
);
  import scm_pkg::*;

  // Derived geometry and arithmetic widths.
  localparam int TOTAL    = STRIPS_PER_ASIC * NUM_ASICS;
  localparam int IDXW     = $clog2(TOTAL);
  localparam int STRW     = $clog2(TOTAL + 1);
  localparam int CMPW     = (STRW > STRIP_W) ? STRW : STRIP_W;
  localparam int POSW     = $clog2(STRIPS_PER_ASIC);
  localparam int SCALED_W = ADC_W + FRAC_BITS;
  localparam int SIGW     = ((SCALED_W > PED_W) ? SCALED_W : PED_W) + 1;
  localparam int SUMW     = SIGW + POSW;
  localparam int CNTW     = POSW + 1;
  localparam int CORW     = SIGW + 1;
  localparam int EW       = CORW - 1;
  localparam int ESW      = EW + POSW;
  localparam int WSW      = ESW + STRW;
  localparam int NUMW     = WSW + CENT_FRAC + 1;
  localparam int SZW      = POSW + 1;
  localparam logic [POSW-1:0] LAST_POS = POSW'(STRIPS_PER_ASIC - 1);
  localparam logic [POSW-1:0] CM_END   = POSW'(STRIPS_PER_ASIC - 2);

  // Controller states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SAMP     = 4'd1;
  localparam logic [3:0] ST_CM_RD    = 4'd2;
  localparam logic [3:0] ST_CM_EV    = 4'd3;
  localparam logic [3:0] ST_CM_DIV   = 4'd4;
  localparam logic [3:0] ST_CM_WAIT  = 4'd5;
  localparam logic [3:0] ST_CL_RD    = 4'd6;
  localparam logic [3:0] ST_CL_EV    = 4'd7;
  localparam logic [3:0] ST_CL_MUL   = 4'd8;
  localparam logic [3:0] ST_CL_ACC   = 4'd9;
  localparam logic [3:0] ST_EM_START = 4'd10;
  localparam logic [3:0] ST_EM_WAIT  = 4'd11;
  localparam logic [3:0] ST_EM_PUSH  = 4'd12;
  localparam logic [3:0] ST_FLUSH    = 4'd13;

  logic [3:0]                 state_r, state_nxt;
  logic [POSW-1:0]            p_r, p_nxt;
  logic [POSW-1:0]            pos_r, pos_nxt;
  logic [IDXW-1:0]            base_r, base_nxt;
  logic [ADC_W-1:0]           adc_r, adc_nxt;
  logic [STRIPS_PER_ASIC-1:0] valid_r, valid_nxt;
  logic signed [SUMW-1:0]     sum_r, sum_nxt;
  logic [CNTW-1:0]            cnt_r, cnt_nxt;
  logic signed [SIGW-1:0]     offset_r, offset_nxt;
  logic                       hit_r, hit_nxt;
  logic [EW-1:0]              e_r, e_nxt;
  logic [WSW-1:0]             prod_r, prod_nxt;
  logic                       open_r, open_nxt;
  logic [POSW-1:0]            last_r, last_nxt;
  logic [ESW-1:0]             esum_r, esum_nxt;
  logic [WSW-1:0]             wsum_r, wsum_nxt;
  logic [SZW-1:0]             size_r, size_nxt;
  logic                       end_r, end_nxt;
  logic [RES_CNT_W-1:0]       res_cnt_r, res_cnt_nxt;
  logic                       pend_v_r, pend_v_nxt;
  res_t                       pend_r, pend_nxt;
  res_t                       new_r, new_nxt;
  logic                       out_valid_r, out_valid_nxt;
  res_t                       out_r, out_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [MULT_W-1:0]          cm_cut_r, hit_cut_r;

  // Strip decode from the input ports.
  logic [CMPW-1:0] strip_x;
  logic            strip_ok;
  logic [IDXW-1:0] idx_c;
  logic [IDXW-1:0] base_c;
  logic [POSW-1:0] pos_c;
  logic            in_fire;

  always_comb begin
    strip_x  = CMPW'(in_strip);
    strip_ok = (strip_x != '0) && (strip_x <= CMPW'(TOTAL));
    idx_c    = IDXW'(strip_x - CMPW'(1));
    base_c   = '0;
    for (int k = 1; k < NUM_ASICS; k++) begin
      if (idx_c >= IDXW'(k * STRIPS_PER_ASIC)) begin
        base_c = IDXW'(k * STRIPS_PER_ASIC);
      end
    end
    pos_c = POSW'(idx_c - base_c);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Calibration store and per-ASIC signal buffer.
  logic [CAL_W-1:0] cal_rdata;
  logic [IDXW-1:0]  cal_raddr;
  logic [SIGW-1:0]  buf_rdata;
  logic [SIGW-1:0]  sig_c;
  cal_t             cal_q;
  cal_t             cal_wr;

  assign cal_wr.dead       = in_dead;
  assign cal_wr.fine_noise = in_fine_noise;
  assign cal_wr.raw_noise  = in_raw_noise;
  assign cal_wr.pedestal   = in_pedestal;
  assign cal_raddr = (state_r == ST_IDLE) ? idx_c : (base_r + IDXW'(p_r));
  assign cal_q     = cal_t'(cal_rdata);
  assign sig_c     = (SIGW'(adc_r) << FRAC_BITS) - SIGW'(cal_q.pedestal);

  scm_ram #(.WIDTH(CAL_W), .DEPTH(TOTAL)) u_cal_ram (
    .clk   (clk),
    .we    (in_fire && (in_mode == MODE_LOAD) && strip_ok),
    .waddr (idx_c),
    .wdata (CAL_W'(cal_wr)),
    .raddr (cal_raddr),
    .rdata (cal_rdata)
  );

  scm_ram #(.WIDTH(SIGW), .DEPTH(STRIPS_PER_ASIC)) u_buf_ram (
    .clk   (clk),
    .we    (state_r == ST_SAMP),
    .waddr (pos_r),
    .wdata (sig_c),
    .raddr (p_r),
    .rdata (buf_rdata)
  );

  // Per-strip evaluation of the buffered signal.
  logic signed [SIGW-1:0] buf_sig;
  logic [SIGW-1:0]        buf_mag;
  logic [PED_W-1:0]       cm_thr;
  logic [PED_W-1:0]       hit_thr;
  logic                   strip_live;
  logic                   cm_take;
  logic signed [CORW-1:0] corr;
  logic                   hit_c;

  always_comb begin
    buf_sig    = signed'(buf_rdata);
    buf_mag    = buf_sig[SIGW-1] ? SIGW'(-buf_sig) : SIGW'(buf_sig);
    cm_thr     = PED_W'(cm_cut_r) * PED_W'(cal_q.raw_noise);
    hit_thr    = PED_W'(hit_cut_r) * PED_W'(cal_q.fine_noise);
    strip_live = valid_r[p_r] && !cal_q.dead;
    cm_take    = strip_live && (p_r != '0) && (p_r < CM_END) &&
                 (buf_mag < SIGW'(cm_thr));
    corr       = CORW'(buf_sig) - CORW'(offset_r);
    hit_c      = strip_live && (p_r != '0) && (p_r != LAST_POS) &&
                 (corr > signed'(CORW'(hit_thr)));
  end

  // Shared divider: rounded common mode, then cluster centroids.
  logic [SUMW-1:0]     cm_mag;
  logic [NUMW-1:0]     div_num;
  logic [ESW-1:0]      div_den;
  logic [NUMW-1:0]     div_quo;
  logic                div_start;
  div_stat_t           div_stat;
  logic signed [SIGW-1:0] q_s;
  logic [STRW-1:0]     strnum;
  logic                slot_free;
  logic [3:0]          ret_state;

  assign cm_mag  = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);
  assign div_num = (state_r == ST_CM_DIV) ?
                   (NUMW'(cm_mag) + NUMW'(cnt_r >> 1)) :
                   ((NUMW'(wsum_r) << CENT_FRAC) + NUMW'(esum_r >> 1));
  assign div_den = (state_r == ST_CM_DIV) ? ESW'(cnt_r) : esum_r;
  assign q_s     = signed'(div_quo[SIGW-1:0]);
  assign strnum  = STRW'(base_r) + STRW'(p_r) + STRW'(1);
  assign slot_free = !out_valid_r || out_ready;
  assign ret_state = end_r ? ST_FLUSH : ST_CL_ACC;

  scm_div #(.NW(NUMW), .DW(ESW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // Sequencer: sample store, common-mode scan, cluster scan, result hand-off.
  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    pos_nxt       = pos_r;
    base_nxt      = base_r;
    adc_nxt       = adc_r;
    valid_nxt     = valid_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    offset_nxt    = offset_r;
    hit_nxt       = hit_r;
    e_nxt         = e_r;
    prod_nxt      = prod_r;
    open_nxt      = open_r;
    last_nxt      = last_r;
    esum_nxt      = esum_r;
    wsum_nxt      = wsum_r;
    size_nxt      = size_r;
    end_nxt       = end_r;
    res_cnt_nxt   = res_cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && strip_ok && (in_mode == MODE_SAMPLE)) begin
          pos_nxt   = pos_c;
          base_nxt  = base_c;
          adc_nxt   = in_adc;
          state_nxt = ST_SAMP;
        end
      end
      ST_SAMP: begin
        valid_nxt[pos_r] = 1'b1;
        if (pos_r == LAST_POS) begin
          p_nxt     = '0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CM_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CM_RD: begin
        state_nxt = ST_CM_EV;
      end
      ST_CM_EV: begin
        if (cm_take) begin
          sum_nxt = sum_r + SUMW'(buf_sig);
          cnt_nxt = cnt_r + CNTW'(1);
        end
        if (p_r == LAST_POS) begin
          p_nxt       = '0;
          open_nxt    = 1'b0;
          res_cnt_nxt = '0;
          end_nxt     = 1'b0;
          state_nxt   = ST_CM_DIV;
        end else begin
          p_nxt     = p_r + POSW'(1);
          state_nxt = ST_CM_RD;
        end
      end
      ST_CM_DIV: begin
        if (cnt_r == '0) begin
          offset_nxt = '0;
          state_nxt  = ST_CL_RD;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_CM_WAIT;
        end
      end
      ST_CM_WAIT: begin
        if (div_stat.done) begin
          offset_nxt = sum_r[SUMW-1] ? -q_s : q_s;
          state_nxt  = ST_CL_RD;
        end
      end
      ST_CL_RD: begin
        state_nxt = ST_CL_EV;
      end
      ST_CL_EV: begin
        hit_nxt   = hit_c;
        e_nxt     = EW'(corr);
        state_nxt = ST_CL_MUL;
      end
      ST_CL_MUL: begin
        prod_nxt  = WSW'(e_r) * WSW'(strnum);
        state_nxt = ST_CL_ACC;
      end
      ST_CL_ACC: begin
        if (hit_r && open_r && (p_r != last_r + POSW'(1))) begin
          // A gap closes the open cluster before this strip starts a new one.
          state_nxt = ST_EM_START;
        end else begin
          if (hit_r) begin
            if (open_r) begin
              esum_nxt = esum_r + ESW'(e_r);
              wsum_nxt = wsum_r + prod_r;
              size_nxt = size_r + SZW'(1);
            end else begin
              esum_nxt = ESW'(e_r);
              wsum_nxt = prod_r;
              size_nxt = SZW'(1);
              open_nxt = 1'b1;
            end
            last_nxt = p_r;
          end
          if (p_r == LAST_POS) begin
            end_nxt   = 1'b1;
            state_nxt = ST_EM_START;
          end else begin
            p_nxt     = p_r + POSW'(1);
            state_nxt = ST_CL_RD;
          end
        end
      end
      ST_EM_START: begin
        if (!open_r || (res_cnt_r == RES_CNT_W'(MAX_RESULTS))) begin
          open_nxt  = 1'b0;
          state_nxt = ret_state;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_EM_WAIT;
        end
      end
      ST_EM_WAIT: begin
        if (div_stat.done) begin
          new_nxt.centroid = (div_quo > NUMW'(CENT_MAX)) ? CENT_W'(CENT_MAX) :
                             div_quo[CENT_W-1:0];
          new_nxt.energy_sum = (32'(esum_r) > 32'(ENERGY_MAX)) ? ENERGY_W'(ENERGY_MAX) :
                               ENERGY_W'(esum_r);
          new_nxt.cluster_size = (32'(size_r) > 32'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX) :
                                 SIZE_W'(size_r);
          state_nxt = ST_EM_PUSH;
        end
      end
      ST_EM_PUSH: begin
        // The previous result goes out once it is known not to be the last one.
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_nxt       = pend_r;
            out_last_nxt  = 1'b0;
            out_valid_nxt = 1'b1;
          end
          pend_nxt    = new_r;
          pend_v_nxt  = 1'b1;
          res_cnt_nxt = res_cnt_r + RES_CNT_W'(1);
          open_nxt    = 1'b0;
          state_nxt   = ret_state;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_nxt       = pend_r;
            out_last_nxt  = 1'b1;
            out_valid_nxt = 1'b1;
          end
          pend_v_nxt = 1'b0;
          valid_nxt  = '0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers with reset, datapath registers without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      open_r      <= 1'b0;
      end_r       <= 1'b0;
      res_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      p_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      open_r      <= open_nxt;
      end_r       <= end_nxt;
      res_cnt_r   <= res_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      p_r         <= p_nxt;
    end
    pos_r      <= pos_nxt;
    base_r     <= base_nxt;
    adc_r      <= adc_nxt;
    offset_r   <= offset_nxt;
    hit_r      <= hit_nxt;
    e_r        <= e_nxt;
    prod_r     <= prod_nxt;
    last_r     <= last_nxt;
    esum_r     <= esum_nxt;
    wsum_r     <= wsum_nxt;
    size_r     <= size_nxt;
    pend_r     <= pend_nxt;
    new_r      <= new_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_cut_r  <= CM_CUT_RST;
      hit_cut_r <= HIT_CUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CM_CUT) begin
        cm_cut_r <= cfg_data;
      end else if (cfg_index == CFG_HIT_CUT) begin
        hit_cut_r <= cfg_data;
      end
    end
  end

  // Output ports.
  assign out_valid        = out_valid_r;
  assign out_centroid     = out_r.centroid;
  assign out_energy_sum   = out_r.energy_sum;
  assign out_cluster_size = out_r.cluster_size;
  assign out_last_in_asic = out_last_r;

  // New results only appear from the push or flush steps.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |->
      ($past(state_r == ST_EM_PUSH) || $past(state_r == ST_FLUSH)))
    else $error("result presented outside push or flush");

  // The per-ASIC result count never passes the limit.
  a_res_limit: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= RES_CNT_W'(MAX_RESULTS)) else $error("too many results in ASIC");

  // Leaving the flush step empties the sample buffer.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && state_nxt == ST_IDLE) |=> (valid_r == '0 && !pend_v_r))
    else $error("buffer not cleared after ASIC");

  // A cluster is never open while no cluster scan is in progress.
  a_idle_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !open_r) else $error("cluster left open");

endmodule
`default_nettype wire

### tb/sv/tb_strip_common_mode_clusterer.sv
// Self-checking testbench for the strip common-mode clusterer.
// Holds its own cluster predictor and drives all three request channels.
// Depends on scm_pkg and the strip_common_mode_clusterer RTL.
`default_nettype none
module tb_strip_common_mode_clusterer;
  timeunit 1ns;
  timeprecision 1ps;
  import scm_pkg::*;

  localparam int STRIPS = 64;
  localparam int ASICS = 10;
  localparam int TOTAL = STRIPS * ASICS;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic [CENT_W-1:0]   centroid;
    logic [ENERGY_W-1:0] energy;
    logic [SIZE_W-1:0]   size;
    logic                last;
  } cluster_t;

  typedef struct {
    logic                mode;
    logic [STRIP_W-1:0]  strip;
    logic [ADC_W-1:0]    adc;
    logic [PED_W-1:0]    ped;
    logic [NOISE_W-1:0]  rn;
    logic [NOISE_W-1:0]  fn;
    logic                dead;
    bit                  typed;
    cluster_t            want;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_mode, in_dead;
  logic [STRIP_W-1:0] in_strip;
  logic [ADC_W-1:0] in_adc;
  logic [PED_W-1:0] in_pedestal;
  logic [NOISE_W-1:0] in_raw_noise, in_fine_noise;
  logic out_valid, out_ready, out_last_in_asic;
  logic [CENT_W-1:0] out_centroid;
  logic [ENERGY_W-1:0] out_energy_sum;
  logic [SIZE_W-1:0] out_cluster_size;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MULT_W-1:0] cfg_data;

  strip_common_mode_clusterer dut (.*);

  // Predictor state: calibration, per-ASIC signal buffer and cut registers.
  logic [PED_W-1:0]   cal_ped [TOTAL];
  logic [NOISE_W-1:0] cal_rn [TOTAL];
  logic [NOISE_W-1:0] cal_fn [TOTAL];
  logic               cal_dead [TOTAL];
  int                 sig_buf [STRIPS];
  bit                 sig_held [STRIPS];
  logic [MULT_W-1:0]  cm_mult, hit_mult;

  cluster_t expected_clusters[$];
  int errors, items_sent, clusters_predicted, clusters_seen, events_run;
  bit calm, hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Append one finished cluster to the list of the current ASIC.
  function automatic void close_cluster(ref cluster_t found[$], input bit open,
                                        input longint unsigned esum,
                                        input longint unsigned wsum, input int size);
    longint unsigned c;
    cluster_t r;
    if (!open || found.size() >= MAX_RESULTS) return;
    c = 0;
    if (esum != 0) c = ((wsum << CENT_FRAC) + esum / 2) / esum;
    r.centroid = (c > CENT_MAX) ? CENT_MAX : c[CENT_W-1:0];
    r.energy = (esum > ENERGY_MAX) ? ENERGY_MAX : esum[ENERGY_W-1:0];
    r.size = (size > SIZE_MAX) ? SIZE_MAX : size[SIZE_W-1:0];
    r.last = 1'b0;
    found.push_back(r);
  endfunction

  // Common-mode estimate and clustering of one completed ASIC.
  function automatic void cluster_asic(int base, ref cluster_t found[$]);
    longint sum, mag, offset, corr;
    int cnt, size, lastp;
    bit open;
    longint unsigned esum, wsum;
    sum = 0; cnt = 0; offset = 0;
    for (int p = 0; p < STRIPS; p++) begin
      if (!sig_held[p] || cal_dead[base+p] || p == 0 || p >= STRIPS - 2) continue;
      mag = (sig_buf[p] < 0) ? -sig_buf[p] : sig_buf[p];
      if (mag < longint'(cm_mult) * longint'(cal_rn[base+p])) begin
        sum += sig_buf[p];
        cnt++;
      end
    end
    if (cnt != 0) begin
      mag = (sum < 0) ? -sum : sum;
      offset = (mag + cnt / 2) / cnt;
      if (sum < 0) offset = -offset;
    end
    open = 0; esum = 0; wsum = 0; size = 0; lastp = 0;
    for (int p = 0; p < STRIPS; p++) begin
      if (!sig_held[p] || cal_dead[base+p] || p == 0 || p == STRIPS - 1) continue;
      corr = sig_buf[p] - offset;
      if (!(corr > longint'(hit_mult) * longint'(cal_fn[base+p]))) continue;
      if (!(open && p == lastp + 1)) begin
        close_cluster(found, open, esum, wsum, size);
        open = 1; esum = 0; wsum = 0; size = 0;
      end
      esum += corr;
      wsum += longint'(corr) * (base + p + 1);
      size++;
      lastp = p;
    end
    close_cluster(found, open, esum, wsum, size);
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    for (int p = 0; p < STRIPS; p++) sig_held[p] = 0;
  endfunction

  // Update the predictor with one accepted request and collect its clusters.
  function automatic void predict_request(row_t r, ref cluster_t found[$]);
    int idx, pos;
    if (r.strip == 0 || r.strip > TOTAL) return;
    idx = r.strip - 1;
    if (r.mode == MODE_LOAD) begin
      cal_ped[idx] = r.ped;
      cal_rn[idx] = r.rn;
      cal_fn[idx] = r.fn;
      cal_dead[idx] = r.dead;
      return;
    end
    pos = idx % STRIPS;
    sig_buf[pos] = int'({r.adc, 4'b0}) - int'(cal_ped[idx]);
    sig_held[pos] = 1;
    if (pos == STRIPS - 1) cluster_asic(idx - pos, found);
  endfunction

  // Offer one request and wait for it to be taken; called and returns at a clock edge.
  task automatic send_request(row_t r);
    cluster_t found[$];
    in_valid <= 1'b1;
    in_mode <= r.mode;
    in_strip <= r.strip;
    in_adc <= r.adc;
    in_pedestal <= r.ped;
    in_raw_noise <= r.rn;
    in_fine_noise <= r.fn;
    in_dead <= r.dead;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    predict_request(r, found);
    if (r.typed) found = '{r.want};
    foreach (found[i]) expected_clusters.push_back(found[i]);
    clusters_predicted += found.size();
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Register write through the configuration channel.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MULT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CM_CUT) cm_mult = val;
    else if (idx == CFG_HIT_CUT) hit_mult = val;
  endtask

  // Let every expected cluster arrive, then give the block time to go idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_clusters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic row_t make_row(logic mode, int strip, int adc);
    row_t r;
    r = '{default: '0};
    r.mode = mode;
    r.strip = strip;
    r.adc = adc;
    return r;
  endfunction

  // Random calibration for one strip, mostly well-behaved.
  function automatic row_t random_load(int strip, bit wild);
    row_t r;
    r = make_row(MODE_LOAD, strip, $urandom_range(0, 4095));
    if (wild) begin
      r.ped = $urandom_range(0, 65535);
      r.rn = $urandom_range(0, 4095);
      r.fn = $urandom_range(0, 4095);
    end else begin
      r.ped = $urandom_range(200, 3800) * 16 + $urandom_range(0, 15);
      r.rn = $urandom_range(16, 320);
      r.fn = $urandom_range(8, 240);
    end
    r.dead = ($urandom_range(0, 19) == 0);
    return r;
  endfunction

  // One ASIC worth of samples: planted hits over a common shift, sometimes broken.
  task automatic run_event(int asic, bit broken);
    int amp [STRIPS];
    int shift, a, start, len;
    row_t r;
    foreach (amp[p]) amp[p] = 0;
    shift = int'($urandom_range(0, 80)) - 40;
    repeat ($urandom_range(0, 6)) begin
      start = $urandom_range(0, STRIPS - 1);
      len = $urandom_range(1, 4);
      for (int p = start; p < start + len && p < STRIPS; p++)
        amp[p] = $urandom_range(50, 1500);
    end
    for (int p = 0; p < STRIPS; p++) begin
      if ($urandom_range(0, 39) == 0) begin
        // Requests for nonexistent strips are dropped by the block.
        r = random_load($urandom_range(0, 1) ? 0 : $urandom_range(TOTAL + 1, 1023), 1);
        r.mode = $urandom_range(0, 1);
        send_request(r);
      end
      if (broken && $urandom_range(0, 7) == 0) continue;
      if (broken && p == STRIPS - 1 && $urandom_range(0, 1)) continue;
      a = int'(cal_ped[asic*STRIPS+p] >> 4) + shift + int'($urandom_range(0, 6)) - 3 + amp[p];
      a = (a < 0) ? 0 : (a > 4095) ? 4095 : a;
      r = make_row(MODE_SAMPLE, asic * STRIPS + p + 1, a);
      r.ped = $urandom_range(0, 65535);
      send_request(r);
      if (broken && $urandom_range(0, 9) == 0) begin
        r.adc = $urandom_range(0, 4095);
        send_request(r);
      end
      if ($urandom_range(0, 49) == 0)
        send_request(random_load($urandom_range(1, TOTAL), $urandom_range(0, 1)));
    end
    events_run++;
  endtask

  // Directed requests: calibration extremes, dropped strips and a lone hit.
  row_t directed [] = '{
    '{MODE_LOAD,   10'd6,    12'd0,    16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_LOAD,   10'd64,   12'd0,    16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd0,    12'hFFF,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_LOAD,   10'd0,    12'd0,    16'hFFFF, 12'hFFF, 12'hFFF, 1'b1, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd1023, 12'hFFF,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_LOAD,   10'd641,  12'd0,    16'h1234, 12'h123, 12'h456, 1'b1, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd641,  12'h800,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd6,    12'd100,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd64,   12'hFFF,  16'h0000, 12'h000, 12'h000, 1'b0, 1,
      '{16'd384, 22'd1600, 6'd1, 1'b1}},
    '{MODE_LOAD,   10'd2,    12'd0,    16'h0100, 12'h020, 12'h001, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_LOAD,   10'd3,    12'd0,    16'h0100, 12'h020, 12'h001, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_LOAD,   10'd4,    12'd0,    16'h0100, 12'h020, 12'h001, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_LOAD,   10'd5,    12'd0,    16'h0000, 12'h040, 12'h002, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd2,    12'h010,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd3,    12'h400,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd4,    12'h000,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd5,    12'h7FF,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd6,    12'hFFF,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}},
    '{MODE_SAMPLE, 10'd64,   12'h000,  16'h0000, 12'h000, 12'h000, 1'b0, 0, '{0, 0, 0, 0}}
  };

  // Cut settings per phase, extremes included.
  int cm_plan [6] = '{6, 0, 15, 15, 3, 9};
  int hit_plan [6] = '{4, 0, 15, 0, 1, 2};

  // Stimulus.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_mode = 1'b0; in_strip = '0; in_adc = '0; in_pedestal = '0;
    in_raw_noise = '0; in_fine_noise = '0; in_dead = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    errors = 0; items_sent = 0; clusters_predicted = 0; clusters_seen = 0; events_run = 0;
    calm = 0; hold_req = 0;
    cm_mult = CM_CUT_RST; hit_mult = HIT_CUT_RST;
    for (int p = 0; p < STRIPS; p++) begin
      sig_buf[p] = 0;
      sig_held[p] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);
    wait_drained();

    // Calibrate every strip before streaming events.
    for (int s = 1; s <= TOTAL; s++) send_request(random_load(s, 0));
    wait_drained();
    write_reg(CFG_SPARE_A, 4'hF);
    write_reg(CFG_SPARE_B, 4'h0);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_CM_CUT, cm_plan[ph]);
      write_reg(CFG_HIT_CUT, hit_plan[ph]);
      calm = (ph == 1);
      hold_req = (ph == 2);
      run_event($urandom_range(0, ASICS - 1), 0);
      run_event($urandom_range(0, ASICS - 1), $urandom_range(0, 2) == 0);
      // The sender waits here until the block has delivered everything.
      wait_drained();
    end
    write_reg(CFG_CM_CUT, CM_CUT_RST);
    write_reg(CFG_HIT_CUT, HIT_CUT_RST);
    for (int k = 0; k < 10 && clusters_predicted < 60; k++) begin
      run_event($urandom_range(0, ASICS - 1), 0);
    end
    wait_drained();

    $display("Sent %0d requests over %0d strip events under six cut settings.",
             items_sent, events_run);
    $display("Checked %0d clusters against %0d predicted.", clusters_seen, clusters_predicted);
    if (errors == 0 && expected_clusters.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Cluster receiver: random back-pressure plus one long hold when asked.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  // Compare each delivered cluster with the oldest prediction.
  always @(negedge clk) begin
    cluster_t want;
    if (rst_n && out_valid && out_ready) begin
      clusters_seen++;
      if (expected_clusters.size() == 0) begin
        $error("unexpected cluster: centroid %0d energy %0d size %0d",
               out_centroid, out_energy_sum, out_cluster_size);
        errors++;
      end else begin
        want = expected_clusters.pop_front();
        if (out_centroid !== want.centroid) begin
          $error("centroid: expected %0d, got %0d", want.centroid, out_centroid);
          errors++;
        end
        if (out_energy_sum !== want.energy) begin
          $error("energy_sum: expected %0d, got %0d", want.energy, out_energy_sum);
          errors++;
        end
        if (out_cluster_size !== want.size) begin
          $error("cluster_size: expected %0d, got %0d", want.size, out_cluster_size);
          errors++;
        end
        if (out_last_in_asic !== want.last) begin
          $error("last_in_asic: expected %0d, got %0d", want.last, out_last_in_asic);
          errors++;
        end
      end
    end
  end

endmodule
`default_nettype wire
